/* rtl/i64set_pkg.sv */
package i64set_pkg;

   // Default table depth
   localparam int DEFAULT_CAPACITY = 64;

   // Field widths fixed by the transaction format
   localparam int OP_W    = 2;
   localparam int KEY_W   = 64;
   localparam int COUNT_W = 7;
   localparam int RSP_W   = 16;

   // Operation codes
   localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // Status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;    // latch a new request, clear scan state
      logic scan;      // issue one table read, advance pointer
      logic apply;     // perform add or clear
      logic load_rsp;  // capture the response payload
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_query;
      logic empty;
      logic scan_last;
   } sts_type;

endpackage

/* rtl/i64set_dp.sv */
module i64set_dp import i64set_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [OP_W-1:0]    req_op,
   input  logic [KEY_W-1:0]   req_key,
   output logic [RSP_W-1:0]   rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   logic [KEY_W-1:0]   mem [CAPACITY];

   logic [OP_W-1:0]    op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic [KEY_W-1:0]   rd_data_ff;
   logic               cmp_valid_ff, cmp_valid_in;
   logic               hit_ff, hit_in;
   logic               rejected_ff, rejected_in;
   logic               found_ff;
   logic               status_ff;
   logic [COUNT_W-1:0] count_out_ff;
   logic               full;
   logic               do_write;

   assign full     = (count_ff == CAP_C);
   assign do_write = cmd.apply && (op_ff == OP_ADD) && !full;

   // Status back to the controller
   assign sts.is_query  = (op_ff == OP_QUERY);
   assign sts.empty     = (count_ff == '0);
   assign sts.scan_last = (CW'(ptr_ff + CW'(1)) == count_ff);

   // Latch the request payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_op;
         key_ff <= req_key;
      end
   end

   // Table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[count_ff[AW-1:0]] <= key_ff;
      end
      if (cmd.scan) begin
         rd_data_ff <= mem[ptr_ff[AW-1:0]];
      end
   end

   // Next count, pointer, hit and reject flags
   always_comb begin
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      hit_in       = hit_ff;
      rejected_in  = rejected_ff;
      cmp_valid_in = cmd.scan;
      if (cmd.accept) begin
         ptr_in      = '0;
         hit_in      = 1'b0;
         rejected_in = 1'b0;
      end else begin
         if (cmd.scan) begin
            ptr_in = CW'(ptr_ff + CW'(1));
         end
         if (cmp_valid_ff && (rd_data_ff == key_ff)) begin
            hit_in = 1'b1;
         end
      end
      if (cmd.apply) begin
         case (op_ff)
            OP_ADD: begin
               if (full) begin
                  rejected_in = 1'b1;
               end else begin
                  count_in = CW'(count_ff + CW'(1));
               end
            end
            OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ptr_ff       <= '0;
         cmp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         rejected_ff  <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         cmp_valid_ff <= cmp_valid_in;
         hit_ff       <= hit_in;
         rejected_ff  <= rejected_in;
      end
   end

   // Capture the response payload
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         found_ff     <= hit_ff && (op_ff == OP_QUERY);
         status_ff    <= rejected_ff ? STATUS_FULL : STATUS_OK;
         count_out_ff <= COUNT_W'(count_ff);
      end
   end

   assign rsp_data = {{(RSP_W - COUNT_W - 2){1'b0}}, count_out_ff, status_ff, found_ff};

   // Count never exceeds the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("entry count above capacity");

   // Reads stay inside the filled part of the table
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> (ptr_ff < count_ff))
      else $error("scan read beyond fill count");

   // A compare only follows a read
   a_cmp_after_read: assert property (@(posedge clock) disable iff (reset)
      cmp_valid_ff |-> $past(cmd.scan))
      else $error("compare without preceding read");

endmodule

/* rtl/i64set_ctrl.sv */
module i64set_ctrl import i64set_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd,
   input  sts_type sts
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.is_query && !sts.empty) begin
               state_in = ST_SCAN;
            end else begin
               cmd.apply = 1'b1;
               state_in  = ST_FINISH;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // let the last compare land
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

   // The last compare is always followed by the response load
   a_drain_to_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |=> (state_ff == ST_FINISH))
      else $error("drain not followed by finish");

   // A new response only comes out of the finish step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> (rsp_tvalid && $past(state_ff == ST_FINISH)))
      else $error("response loaded outside finish");

   // A scan leaves only through the drain step
   a_scan_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("scan left without drain");

endmodule

/* rtl/int64_set_membership_table.sv */
// Add, clear and unused codes apply in the execute step and respond from the finish step;
// a nonempty query first scans every stored entry, then drains, then finishes.
// A new request is taken only in idle, after the previous one has finished; the
// scan reads the single table read port once per cycle, one 64-bit compare each.
// A finished response waits in an output register while the next request runs.
// Reset (synchronous, active high) empties the table; entries are not cleared.
module int64_set_membership_table import i64set_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [KEY_W-1:0]   req_tdata,   // [63:0] key_value
   input  logic [OP_W-1:0]    req_tuser,   // [1:0] operation
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata    // [0] found, [1] status, [8:2] entry_count
);

   cmd_type cmd;
   sts_type sts;

   i64set_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   i64set_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_op   (req_tuser),
      .req_key  (req_tdata),
      .rsp_data (rsp_tdata)
   );

endmodule
